/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/cstat_pkg.sv */
// ----------------------------------------------------------------------------
// cstat_pkg
// Widths, result kinds and transfer payload types of the curve statistics core.
// ----------------------------------------------------------------------------
package cstat_pkg;

	localparam int COMP_W  = 2;
	localparam int TIME_W  = 32;
	localparam int CONC_W  = 32;
	localparam int KIND_W  = 4;
	localparam int SECS_W  = 24;
	localparam int VALUE_W = 64;

	// c + previous c, one carry bit
	localparam int SUM_W   = CONC_W + 1;
	// shared adder: room for a 64-bit signed sum plus carry and sign
	localparam int ADD_W   = VALUE_W + 2;

	// (c0 + c1) * dt is Q29.36; halve and move to Q32.32
	localparam int AREA_SHIFT = 5;
	localparam int MAG_W      = SUM_W + TIME_W - AREA_SHIFT;

	localparam int CONC_SHIFT = 16;
	localparam int IVAL_SHIFT = 12;
	localparam int SECS_FRAC  = 20;
	localparam int MEAN_SHIFT = 20;
	// 24 = 3 << 3, so auc24 numerator is (3 * auc) << 23
	localparam int A24_SHIFT  = 23;

	// long division numerator, wide enough for (3 * |auc|) << 23
	localparam int DIV_W     = VALUE_W + 1 + A24_SHIFT;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [TIME_W-1:0] SEC_PER_HOUR = TIME_W'(3600);

	localparam logic signed [VALUE_W-1:0] VAL_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};
	// -1.0 in Q32.32
	localparam logic signed [VALUE_W-1:0] A24_UNDEF = {{(VALUE_W-32){1'b1}}, 32'd0};

	localparam logic [1:0] SLOPE_FLAT = 2'd0;
	localparam logic [1:0] SLOPE_UP   = 2'd1;
	localparam logic [1:0] SLOPE_DOWN = 2'd2;

	localparam logic [KIND_W-1:0] KIND_MAX      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_MIN      = 4'd1;
	localparam logic [KIND_W-1:0] KIND_RESIDUAL = 4'd2;
	localparam logic [KIND_W-1:0] KIND_AUC      = 4'd3;
	localparam logic [KIND_W-1:0] KIND_CUM_AUC  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_MEAN     = 4'd5;
	localparam logic [KIND_W-1:0] KIND_PEAK     = 4'd6;
	localparam logic [KIND_W-1:0] KIND_INTERVAL = 4'd7;
	localparam logic [KIND_W-1:0] KIND_AUC24    = 4'd8;

	typedef struct packed {
		logic [COMP_W-1:0] compartment;
		logic [TIME_W-1:0] time_hours;
		logic [CONC_W-1:0] concentration;
		logic              first_sample;
		logic              last_sample;
	} sample_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [COMP_W-1:0]         result_compartment;
		logic [SECS_W-1:0]         time_seconds;
		logic signed [VALUE_W-1:0] value;
		logic                      undefined;
		logic                      last_result;
	} result_t;

endpackage

/* hw/rtl/cstat_stream_if.sv */
// ----------------------------------------------------------------------------
// cstat_stream_if
// Valid/ready stream channel; one transfer when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cstat_stream_if #(
	parameter type data_t = logic
);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

/* hw/rtl/curve_cycle_statistics_core.sv */
// ----------------------------------------------------------------------------
// curve_cycle_statistics_core
// Per-cycle curve statistics: local extrema, trapezoidal AUC, cumulative AUC
// per compartment, mean, peak, interval and AUC scaled to 24 hours.
//
// Samples arrive one per transfer on the sample channel and results leave one
// per transfer on the result channel through a single output register, so a
// sample can be taken while the last result still waits. The block works on
// one sample at a time. A first-marked sample that is not also last needs only
// its transfer. A sample without a first mark goes through transfer, area
// product on the shared 32x32 multiplier, area assembly and accumulation on
// the shared 66-bit adder, plus an extremum time conversion and transfer when
// a local extremum is reported. A last-marked sample then adds, for a nonzero
// interval, two restoring divisions, one quotient bit per cycle over an 88-bit
// numerator, for the mean and for AUC24, then seven result transfers with two
// more multiplier passes for the times in seconds. There is no clearing pass
// after reset; all state is in flip-flops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module curve_cycle_statistics_core
	import cstat_pkg::*;
#(
	parameter int COMPARTMENTS = 4
) (
	input logic          clk,
	input logic          arst_n,
	cstat_stream_if.sink   sample,
	cstat_stream_if.source result
);

	localparam int SLOT_W     = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
	// a 2-bit compartment needs at most three subtractions to reduce
	localparam int SLOT_STEPS = (1 << COMP_W) - 1;

	// sequencer codes
	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] S_IDLE = 5'd0;   // waiting for a sample
	localparam logic [STATE_W-1:0] S_AMUL = 5'd1;   // (c0 + c1)[31:0] * |dt|
	localparam logic [STATE_W-1:0] S_AMAG = 5'd2;   // add carry term, scale
	localparam logic [STATE_W-1:0] S_AACC = 5'd3;   // cycle AUC += +/- segment
	localparam logic [STATE_W-1:0] S_EMUL = 5'd4;   // extremum time to seconds
	localparam logic [STATE_W-1:0] S_EOUT = 5'd5;   // extremum transfer
	localparam logic [STATE_W-1:0] S_CUM  = 5'd6;   // cumulative AUC, interval
	localparam logic [STATE_W-1:0] S_ABS  = 5'd7;   // magnitudes, load divider
	localparam logic [STATE_W-1:0] S_DIV  = 5'd8;   // one quotient bit
	localparam logic [STATE_W-1:0] S_DFIN = 5'd9;   // sign and saturate
	localparam logic [STATE_W-1:0] S_TRIP = 5'd10;  // 3 * |auc| for AUC24
	localparam logic [STATE_W-1:0] S_RMUL = 5'd11;
	localparam logic [STATE_W-1:0] S_ROUT = 5'd12;
	localparam logic [STATE_W-1:0] S_AUC  = 5'd13;
	localparam logic [STATE_W-1:0] S_CUMO = 5'd14;
	localparam logic [STATE_W-1:0] S_MEAN = 5'd15;
	localparam logic [STATE_W-1:0] S_PMUL = 5'd16;
	localparam logic [STATE_W-1:0] S_POUT = 5'd17;
	localparam logic [STATE_W-1:0] S_INT  = 5'd18;
	localparam logic [STATE_W-1:0] S_A24  = 5'd19;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	logic [STATE_W-1:0] state_q, state_d;

	// cycle state, cleared by reset
	logic [CONC_W-1:0]         prev_c_q;
	logic [TIME_W-1:0]         prev_t_q;
	logic [TIME_W-1:0]         start_t_q;
	logic [CONC_W-1:0]         peak_c_q;
	logic [TIME_W-1:0]         peak_t_q;
	logic [1:0]                slope_q;
	logic signed [VALUE_W-1:0] cyc_auc_q;
	logic signed [VALUE_W-1:0] cum_q [COMPARTMENTS];
	logic                      ext_vld_q;
	logic                      pass_q;        // 0: mean division, 1: AUC24

	// captured sample and working registers
	logic [COMP_W-1:0]         in_comp_q;
	logic [TIME_W-1:0]         in_t_q;
	logic [CONC_W-1:0]         in_c_q;
	logic                      in_last_q;
	logic [SUM_W-1:0]          sum_a_q;
	logic [TIME_W-1:0]         dt_mag_q;
	logic                      dt_neg_q;
	logic [KIND_W-1:0]         ext_kind_q;
	logic [CONC_W-1:0]         ext_c_q;
	logic [TIME_W-1:0]         ext_t_q;
	logic [VALUE_W-1:0]        mul_q;
	logic [MAG_W-1:0]          mag_q;
	logic signed [TIME_W:0]    ival_q;
	logic [VALUE_W-1:0]        absauc_q;
	logic                      neg_q;

	// divider
	logic [DIV_W-1:0]          num_q;
	logic [TIME_W-1:0]         rem_q;
	logic [TIME_W-1:0]         dvs_q;
	logic [VALUE_W-1:0]        quo_q;
	logic                      ovf_q;
	logic [DIV_CNT_W-1:0]      cnt_q;

	logic signed [VALUE_W-1:0] mean_q;
	logic signed [VALUE_W-1:0] a24_q;
	logic                      undef_q;

	// output register
	result_t out_q, out_d;
	logic    out_vld_q;
	logic    out_load;
	logic    out_free;

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------
	function automatic logic signed [VALUE_W-1:0] sat_value(
		input logic signed [ADD_W-1:0] x
	);
		logic fits;
		fits = (x[ADD_W-1:VALUE_W-1] == '0) || (x[ADD_W-1:VALUE_W-1] == '1);
		if (fits)
			return signed'(x[VALUE_W-1:0]);
		else if (x[ADD_W-1])
			return VAL_MIN;
		else
			return VAL_MAX;
	endfunction

	// concentration Q16.16 to Q32.32
	function automatic logic signed [VALUE_W-1:0] conc_value(input logic [CONC_W-1:0] c);
		return signed'(VALUE_W'({c, {CONC_SHIFT{1'b0}}}));
	endfunction

	// ------------------------------------------------------------------
	// Sample transfer and per-sample decode
	// ------------------------------------------------------------------
	logic accept;
	logic [1:0] slope_d;
	logic ext_hit;
	logic dt_neg_d;

	assign sample.ready = (state_q == S_IDLE);
	assign accept = sample.valid && sample.ready;

	assign slope_d = (sample.data.concentration > prev_c_q) ? SLOPE_UP :
	                 (sample.data.concentration < prev_c_q) ? SLOPE_DOWN : SLOPE_FLAT;
	// strict change of direction only; a flat step breaks the run
	assign ext_hit = ((slope_q == SLOPE_UP) && (slope_d == SLOPE_DOWN)) ||
	                 ((slope_q == SLOPE_DOWN) && (slope_d == SLOPE_UP));
	assign dt_neg_d = sample.data.time_hours < prev_t_q;

	// compartment folded onto the cumulative store
	logic [COMP_W-1:0] slot_red;
	logic [SLOT_W-1:0] slot;

	always_comb begin
		slot_red = in_comp_q;
		for (int i = 0; i < SLOT_STEPS; i++) begin
			if (int'(slot_red) >= COMPARTMENTS)
				slot_red = slot_red - COMP_W'(COMPARTMENTS);
		end
	end

	assign slot = SLOT_W'(slot_red);

	// ------------------------------------------------------------------
	// Shared multiplier: area product and hours to seconds
	// ------------------------------------------------------------------
	logic [TIME_W-1:0]  mul_x, mul_y;
	logic [VALUE_W-1:0] mul_p;
	logic               mul_en;

	always_comb begin
		mul_x  = '0;
		mul_y  = SEC_PER_HOUR;
		mul_en = 1'b0;
		case (state_q)
			S_AMUL: begin
				mul_x  = sum_a_q[TIME_W-1:0];
				mul_y  = dt_mag_q;
				mul_en = 1'b1;
			end
			S_EMUL: begin
				mul_x  = ext_t_q;
				mul_en = 1'b1;
			end
			S_RMUL: begin
				mul_x  = in_t_q;
				mul_en = 1'b1;
			end
			S_PMUL: begin
				mul_x  = peak_t_q;
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	logic [SECS_W-1:0] secs;
	assign secs = mul_q[SECS_FRAC +: SECS_W];

	// ------------------------------------------------------------------
	// Shared adder
	// ------------------------------------------------------------------
	logic signed [ADD_W-1:0] add_a, add_b, add_sum;
	logic                    add_sub;

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			S_AMAG: begin
				// high bit of c0 + c1 contributes |dt| << 32
				add_a = ADD_W'(mul_q);
				add_b = sum_a_q[SUM_W-1] ? ADD_W'({dt_mag_q, 32'd0}) : '0;
			end
			S_AACC: begin
				add_a   = ADD_W'(cyc_auc_q);
				add_b   = ADD_W'(mag_q);
				add_sub = dt_neg_q;
			end
			S_CUM: begin
				add_a = ADD_W'(cum_q[slot]);
				add_b = ADD_W'(cyc_auc_q);
			end
			S_ABS: begin
				add_b   = ADD_W'(cyc_auc_q);
				add_sub = 1'b1;
			end
			S_DFIN: begin
				add_b   = ADD_W'(quo_q);
				add_sub = 1'b1;
			end
			S_TRIP: begin
				add_a = ADD_W'(absauc_q);
				add_b = ADD_W'({absauc_q, 1'b0});
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

	// ------------------------------------------------------------------
	// Interval, magnitudes and one restoring division step
	// ------------------------------------------------------------------
	logic signed [TIME_W:0] ival_d, ival_neg;
	logic [VALUE_W-1:0]     absauc_d;
	logic [TIME_W:0]        div_trial, div_diff;
	logic                   div_ge;
	logic signed [VALUE_W-1:0] div_res;

	assign ival_d   = $signed({1'b0, in_t_q}) - $signed({1'b0, start_t_q});
	assign ival_neg = -ival_q;
	assign absauc_d = cyc_auc_q[VALUE_W-1] ? add_sum[VALUE_W-1:0] : VALUE_W'(cyc_auc_q);

	assign div_trial = {rem_q, num_q[DIV_W-1]};
	assign div_diff  = div_trial - {1'b0, dvs_q};
	assign div_ge    = div_trial >= {1'b0, dvs_q};

	// quotient past the signed range saturates by sign
	assign div_res = (ovf_q || quo_q[VALUE_W-1]) ? (neg_q ? VAL_MIN : VAL_MAX) :
	                 neg_q ? signed'(add_sum[VALUE_W-1:0]) : signed'(quo_q);

	// ------------------------------------------------------------------
	// Sequencer and result selection
	// ------------------------------------------------------------------
	assign out_free = !out_vld_q || result.ready;

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = '0;
		out_d.result_compartment = in_comp_q;
		unique case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					if (!sample.data.first_sample)
						state_d = S_AMUL;
					else if (sample.data.last_sample)
						state_d = S_CUM;
				end
			end
			S_AMUL: state_d = S_AMAG;
			S_AMAG: state_d = S_AACC;
			S_AACC: begin
				if (ext_vld_q)
					state_d = S_EMUL;
				else if (in_last_q)
					state_d = S_CUM;
				else
					state_d = S_IDLE;
			end
			S_EMUL: state_d = S_EOUT;
			S_EOUT: begin
				out_d.kind         = ext_kind_q;
				out_d.time_seconds = secs;
				out_d.value        = conc_value(ext_c_q);
				out_d.last_result  = !in_last_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = in_last_q ? S_CUM : S_IDLE;
				end
			end
			S_CUM: state_d = S_ABS;
			S_ABS: state_d = (ival_q == '0) ? S_RMUL : S_DIV;
			S_DIV: begin
				if (cnt_q == DIV_CNT_W'(1))
					state_d = S_DFIN;
			end
			S_DFIN: state_d = pass_q ? S_RMUL : S_TRIP;
			S_TRIP: state_d = S_DIV;
			S_RMUL: state_d = S_ROUT;
			S_ROUT: begin
				out_d.kind         = KIND_RESIDUAL;
				out_d.time_seconds = secs;
				out_d.value        = conc_value(in_c_q);
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_AUC;
				end
			end
			S_AUC: begin
				out_d.kind  = KIND_AUC;
				out_d.value = cyc_auc_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_CUMO;
				end
			end
			S_CUMO: begin
				out_d.kind  = KIND_CUM_AUC;
				out_d.value = cum_q[slot];
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_MEAN;
				end
			end
			S_MEAN: begin
				out_d.kind      = KIND_MEAN;
				out_d.value     = mean_q;
				out_d.undefined = undef_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_PMUL;
				end
			end
			S_PMUL: state_d = S_POUT;
			S_POUT: begin
				out_d.kind         = KIND_PEAK;
				out_d.time_seconds = secs;
				out_d.value        = conc_value(peak_c_q);
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_INT;
				end
			end
			S_INT: begin
				out_d.kind  = KIND_INTERVAL;
				out_d.value = VALUE_W'(ival_q) <<< IVAL_SHIFT;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_A24;
				end
			end
			S_A24: begin
				out_d.kind        = KIND_AUC24;
				out_d.value       = a24_q;
				out_d.undefined   = undef_q;
				out_d.last_result = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control and cycle state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			prev_c_q  <= '0;
			prev_t_q  <= '0;
			start_t_q <= '0;
			peak_c_q  <= '0;
			peak_t_q  <= '0;
			slope_q   <= SLOPE_FLAT;
			cyc_auc_q <= '0;
			ext_vld_q <= 1'b0;
			pass_q    <= 1'b0;
			for (int i = 0; i < COMPARTMENTS; i++)
				cum_q[i] <= '0;
		end else begin
			state_q <= state_d;

			if (out_load)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;

			if (accept) begin
				prev_c_q <= sample.data.concentration;
				prev_t_q <= sample.data.time_hours;
				if (sample.data.first_sample) begin
					// new cycle: peak restarts from the first sample at the start time
					cyc_auc_q <= '0;
					slope_q   <= SLOPE_FLAT;
					start_t_q <= sample.data.time_hours;
					peak_c_q  <= sample.data.concentration;
					peak_t_q  <= sample.data.time_hours;
					ext_vld_q <= 1'b0;
				end else begin
					slope_q   <= slope_d;
					ext_vld_q <= ext_hit;
					// strict: earliest sample keeps a tie
					if (sample.data.concentration > peak_c_q) begin
						peak_c_q <= sample.data.concentration;
						peak_t_q <= sample.data.time_hours;
					end
				end
			end

			if (state_q == S_AACC)
				cyc_auc_q <= sat_value(add_sum);
			if (state_q == S_CUM)
				cum_q[slot] <= sat_value(add_sum);
			if (state_q == S_ABS)
				pass_q <= 1'b0;
			if (state_q == S_TRIP)
				pass_q <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			in_comp_q  <= sample.data.compartment;
			in_t_q     <= sample.data.time_hours;
			in_c_q     <= sample.data.concentration;
			in_last_q  <= sample.data.last_sample;
			sum_a_q    <= SUM_W'(sample.data.concentration) + SUM_W'(prev_c_q);
			dt_neg_q   <= dt_neg_d;
			dt_mag_q   <= dt_neg_d ? (prev_t_q - sample.data.time_hours) :
			                         (sample.data.time_hours - prev_t_q);
			ext_kind_q <= (slope_q == SLOPE_UP) ? KIND_MAX : KIND_MIN;
			ext_c_q    <= prev_c_q;
			ext_t_q    <= prev_t_q;
		end

		if (mul_en)
			mul_q <= mul_p;

		if (out_load)
			out_q <= out_d;

		unique case (state_q)
			S_AMAG: begin
				mag_q <= add_sum[AREA_SHIFT +: MAG_W];
			end
			S_CUM: begin
				ival_q <= ival_d;
			end
			S_ABS: begin
				absauc_q <= absauc_d;
				neg_q    <= cyc_auc_q[VALUE_W-1] ^ ival_q[TIME_W];
				dvs_q    <= ival_q[TIME_W] ? ival_neg[TIME_W-1:0] : ival_q[TIME_W-1:0];
				num_q    <= DIV_W'({absauc_d, {MEAN_SHIFT{1'b0}}});
				rem_q    <= '0;
				quo_q    <= '0;
				ovf_q    <= 1'b0;
				cnt_q    <= DIV_CNT_W'(DIV_W);
				// zero interval: saturated mean, AUC24 of -1.0
				undef_q  <= (ival_q == '0);
				mean_q   <= cyc_auc_q[VALUE_W-1] ? VAL_MIN : VAL_MAX;
				a24_q    <= A24_UNDEF;
			end
			S_DIV: begin
				rem_q <= div_ge ? div_diff[TIME_W-1:0] : div_trial[TIME_W-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[VALUE_W-2:0], div_ge};
				ovf_q <= ovf_q | quo_q[VALUE_W-1];
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			S_DFIN: begin
				if (pass_q)
					a24_q <= div_res;
				else
					mean_q <= div_res;
			end
			S_TRIP: begin
				num_q <= DIV_W'({add_sum[VALUE_W:0], {A24_SHIFT{1'b0}}});
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= DIV_CNT_W'(DIV_W);
			end
			default: begin
			end
		endcase
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a first mark without a last mark leaves nothing to do
	`ASSERT_NEXT(a_first_only_quick, clk, arst_n, sample.valid && sample.ready && sample.data.first_sample && !sample.data.last_sample, sample.ready, "first-only sample held the block busy")
	// partial remainder stays below the divisor
	`ASSERT_IMPLIES(a_div_rem_bound, clk, arst_n, state_q == S_DIV, rem_q < dvs_q, "divider remainder out of range")
	// AUC24 closes the burst of end-of-cycle results
	`ASSERT_IMPLIES(a_auc24_last, clk, arst_n, result.valid && (result.data.kind == KIND_AUC24), result.data.last_result, "AUC24 transfer without last mark")
	// only mean and AUC24 may be flagged undefined
	`ASSERT_IMPLIES(a_undef_kind, clk, arst_n, result.valid && result.data.undefined, (result.data.kind == KIND_MEAN) || (result.data.kind == KIND_AUC24), "undefined flag on wrong result kind")

endmodule

/* dv/tb_curve_cycle_statistics_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_curve_cycle_statistics_core
// Stream-level test of the curve statistics core. A scoreboard class holds a
// bit-exact predictor of extrema, trapezoidal AUC, cumulative AUC, mean, peak,
// interval and AUC24, and checks every result transfer against it in order.
// ----------------------------------------------------------------------------
module tb_curve_cycle_statistics_core;

	import cstat_pkg::*;

	localparam int COMPARTMENTS = 4;
	// directed samples plus roughly 480 random ones
	localparam int TOTAL_ITEMS  = 500;
	localparam int DRAIN_ITEMS  = 250;
	localparam int CALM_FROM    = 320;
	localparam int CALM_TO      = 420;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [TIME_W-1:0] HOUR     = 32'h0010_0000; // 1.0 in Q12.20
	localparam logic [CONC_W-1:0] CONC_TOP = 32'hFFFF_FFFF;

	// ------------------------------------------------------------------------
	// Scoreboard: predictor state plus the queue of results still owed.
	// ------------------------------------------------------------------------
	class cycle_stats_scoreboard;
		result_t owed[$];
		result_t batch[$];
		int      mismatches;
		int      checked;

		logic signed [VALUE_W-1:0] cum_auc [COMPARTMENTS];
		logic signed [VALUE_W-1:0] run_auc;
		logic [CONC_W-1:0]         last_conc;
		logic [TIME_W-1:0]         last_time;
		logic [TIME_W-1:0]         cycle_start;
		logic [CONC_W-1:0]         peak_conc;
		logic [TIME_W-1:0]         peak_at;
		logic [1:0]                trend;

		function new();
			mismatches  = 0;
			checked     = 0;
			run_auc     = '0;
			last_conc   = '0;
			last_time   = '0;
			cycle_start = '0;
			peak_conc   = '0;
			peak_at     = '0;
			trend       = SLOPE_FLAT;
			foreach (cum_auc[i])
				cum_auc[i] = '0;
		endfunction

		// signed add clamped to the 64-bit range
		function logic signed [VALUE_W-1:0] sat_sum(logic signed [VALUE_W-1:0] a,
				logic signed [VALUE_W-1:0] b);
			logic [VALUE_W:0] s;
			s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
			if (s[VALUE_W] != s[VALUE_W-1])
				return s[VALUE_W] ? VAL_MIN : VAL_MAX;
			return s[VALUE_W-1:0];
		endfunction

		// num * mult / den, truncated toward zero, clamped
		function logic signed [VALUE_W-1:0] ratio(logic signed [VALUE_W-1:0] num,
				logic [VALUE_W-1:0] mult, logic signed [VALUE_W-1:0] den);
			logic                neg;
			logic [VALUE_W-1:0]  mag_n;
			logic [VALUE_W-1:0]  mag_d;
			logic [127:0]        q;
			neg   = num[VALUE_W-1] ^ den[VALUE_W-1];
			mag_n = num[VALUE_W-1] ? (64'd0 - num) : num;
			mag_d = den[VALUE_W-1] ? (64'd0 - den) : den;
			q     = (128'(mag_n) * 128'(mult)) / 128'(mag_d);
			if (q[127:VALUE_W-1] != '0)
				return neg ? VAL_MIN : VAL_MAX;
			return neg ? -$signed(q[VALUE_W-1:0]) : $signed(q[VALUE_W-1:0]);
		endfunction

		// hours in Q12.20 to whole seconds, 24 bits kept
		function logic [SECS_W-1:0] to_secs(logic [TIME_W-1:0] t);
			logic [63:0] p;
			p = 64'(t) * 64'd3600;
			return p[SECS_FRAC+SECS_W-1:SECS_FRAC];
		endfunction

		function void emit(logic [KIND_W-1:0] kind, logic [COMP_W-1:0] comp,
				logic [SECS_W-1:0] secs, logic signed [VALUE_W-1:0] value, logic undef);
			result_t r;
			r.kind               = kind;
			r.result_compartment = comp;
			r.time_seconds       = secs;
			r.value              = value;
			r.undefined          = undef;
			r.last_result        = 1'b0;
			batch.push_back(r);
		endfunction

		// accepted sample: advance the predictor and queue what it causes
		function void note_sample(sample_t s);
			logic [1:0]                slope;
			logic [SUM_W-1:0]          csum;
			logic [TIME_W-1:0]         span;
			logic [SUM_W+TIME_W-1:0]   area;
			logic signed [VALUE_W-1:0] seg;
			logic signed [VALUE_W-1:0] ival;
			logic signed [VALUE_W-1:0] mean_v;
			logic signed [VALUE_W-1:0] a24_v;
			logic                      undef;
			int                        slot;
			batch.delete();
			if (s.first_sample) begin
				run_auc     = '0;
				trend       = SLOPE_FLAT;
				cycle_start = s.time_hours;
				peak_conc   = '0;
				peak_at     = s.time_hours;
			end else begin
				slope = (s.concentration > last_conc) ? SLOPE_UP :
					(s.concentration < last_conc) ? SLOPE_DOWN : SLOPE_FLAT;
				csum  = {1'b0, s.concentration} + {1'b0, last_conc};
				span  = (s.time_hours < last_time) ? (last_time - s.time_hours)
					: (s.time_hours - last_time);
				area  = (SUM_W+TIME_W)'(csum) * (SUM_W+TIME_W)'(span);
				seg   = $signed(64'(area >> AREA_SHIFT));
				if (s.time_hours < last_time)
					seg = -seg;
				if (trend == SLOPE_UP && slope == SLOPE_DOWN)
					emit(KIND_MAX, s.compartment, to_secs(last_time),
						64'(last_conc) << CONC_SHIFT, 1'b0);
				else if (trend == SLOPE_DOWN && slope == SLOPE_UP)
					emit(KIND_MIN, s.compartment, to_secs(last_time),
						64'(last_conc) << CONC_SHIFT, 1'b0);
				trend   = slope;
				run_auc = sat_sum(run_auc, seg);
			end
			// strict: earliest sample keeps the peak on a tie
			if (s.concentration > peak_conc) begin
				peak_conc = s.concentration;
				peak_at   = s.time_hours;
			end
			last_conc = s.concentration;
			last_time = s.time_hours;

			if (s.last_sample) begin
				slot          = int'(s.compartment) % COMPARTMENTS;
				ival          = $signed({32'd0, s.time_hours}) - $signed({32'd0, cycle_start});
				cum_auc[slot] = sat_sum(cum_auc[slot], run_auc);
				if (ival == 0) begin
					mean_v = run_auc[VALUE_W-1] ? VAL_MIN : VAL_MAX;
					a24_v  = A24_UNDEF;
					undef  = 1'b1;
				end else begin
					mean_v = ratio(run_auc, 64'd1 << MEAN_SHIFT, ival);
					a24_v  = ratio(run_auc, 64'd24 << MEAN_SHIFT, ival);
					undef  = 1'b0;
				end
				emit(KIND_RESIDUAL, s.compartment, to_secs(s.time_hours),
					64'(s.concentration) << CONC_SHIFT, 1'b0);
				emit(KIND_AUC, s.compartment, '0, run_auc, 1'b0);
				emit(KIND_CUM_AUC, s.compartment, '0, cum_auc[slot], 1'b0);
				emit(KIND_MEAN, s.compartment, '0, mean_v, undef);
				emit(KIND_PEAK, s.compartment, to_secs(peak_at),
					64'(peak_conc) << CONC_SHIFT, 1'b0);
				emit(KIND_INTERVAL, s.compartment, '0, ival <<< IVAL_SHIFT, 1'b0);
				emit(KIND_AUC24, s.compartment, '0, a24_v, undef);
			end

			if (batch.size() > 0)
				batch[batch.size()-1].last_result = 1'b1;
			foreach (batch[i])
				owed.push_back(batch[i]);
		endfunction

		function void flag(string what, result_t want, result_t got);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t mismatch (%s)", $realtime, what);
				$display("  exp kind %0d comp %0d secs %0d value %h undef %b last %b",
					want.kind, want.result_compartment, want.time_seconds,
					want.value, want.undefined, want.last_result);
				$display("  got kind %0d comp %0d secs %0d value %h undef %b last %b",
					got.kind, got.result_compartment, got.time_seconds,
					got.value, got.undefined, got.last_result);
			end
		endfunction

		// accepted result: compare with the oldest owed one
		function void check_result(result_t got);
			result_t want;
			checked++;
			if (owed.size() == 0) begin
				flag("no result owed", '0, got);
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind
					|| got.result_compartment !== want.result_compartment
					|| got.time_seconds !== want.time_seconds
					|| got.value !== want.value
					|| got.undefined !== want.undefined
					|| got.last_result !== want.last_result)
				flag("field differs", want, got);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cstat_stream_if #(.data_t(sample_t)) samples ();
	cstat_stream_if #(.data_t(result_t)) results ();

	curve_cycle_statistics_core #(
		.COMPARTMENTS(COMPARTMENTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(samples),
		.result(results)
	);

	cycle_stats_scoreboard stats = new();

	int n_items = 0;
	int cycles  = 0;
	// both sides stop idling while this is set
	bit calm    = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit; generous against the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Observe both channels on the edge that completes a transfer. Values read
	// here are the pre-edge ones, so nothing depends on process order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples.valid && samples.ready)
				stats.note_sample(samples.data);
			if (results.valid && results.ready)
				stats.check_result(results.data);
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, one long hold-off once the run is
	// under way so the single output register fills and the input stalls.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int  hold;
		bit  held;
		hold = 0;
		held = 1'b0;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && stats.checked >= HOLD_AFTER) begin
				hold = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold > 0) begin
				results.ready <= 1'b0;
				hold--;
			end else begin
				results.ready <= calm || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------------
	// One sample transfer. An idle gap drops valid for at least one edge, so
	// valid is never lowered and raised in the same step.
	task automatic send_sample(input logic [COMP_W-1:0] comp, input logic [TIME_W-1:0] t,
			input logic [CONC_W-1:0] c, input logic first, input logic last);
		sample_t s;
		s.compartment   = comp;
		s.time_hours    = t;
		s.concentration = c;
		s.first_sample  = first;
		s.last_sample   = last;
		if (!calm && $urandom_range(0, 99) < 16) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.data  <= s;
		do @(posedge clk); while (!samples.ready);
		n_items++;
	endtask

	initial begin : stimulus
		int               pick;
		int               len;
		int               mode;
		int               rounds;
		bit               drained;
		logic [COMP_W-1:0] comp;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic [CONC_W-1:0] c;
		drained = 1'b0;
		samples.valid <= 1'b0;
		samples.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// -- directed --
		// no first mark after reset: carries on from the cleared state;
		// rising then falling gives a maximum at the previous sample
		send_sample(2'd1, 3 * HOUR, 32'h0001_0000, 1'b0, 1'b0);
		send_sample(2'd1, 5 * HOUR, 32'h0000_8000, 1'b0, 1'b1);
		// first and last on one sample: zero interval, mean saturated, undefined
		send_sample(2'd2, 7 * HOUR, 32'h0002_0000, 1'b1, 1'b1);
		// max, min, a flat step clearing the slope, peak tie, min at the close
		send_sample(2'd3, 0,        32'h0000_0000, 1'b1, 1'b0);
		send_sample(2'd3, 1 * HOUR, 32'h0005_0000, 1'b0, 1'b0);
		send_sample(2'd3, 2 * HOUR, 32'h0001_0000, 1'b0, 1'b0);
		send_sample(2'd3, 3 * HOUR, 32'h0005_0000, 1'b0, 1'b0);
		send_sample(2'd3, 4 * HOUR, 32'h0005_0000, 1'b0, 1'b0);
		send_sample(2'd3, 5 * HOUR, 32'h0001_0000, 1'b0, 1'b0);
		send_sample(2'd3, 6 * HOUR, 32'h0003_0000, 1'b0, 1'b1);
		// time runs backwards then returns: zero interval, negative AUC
		send_sample(2'd0, 8 * HOUR, 32'h0001_0000, 1'b1, 1'b0);
		send_sample(2'd0, 4 * HOUR, CONC_TOP,      1'b0, 1'b0);
		send_sample(2'd0, 8 * HOUR, 32'h0000_0000, 1'b0, 1'b1);
		// full-span out and back: huge AUC over a tiny interval saturates mean
		send_sample(2'd1, 0,            CONC_TOP, 1'b1, 1'b0);
		send_sample(2'd1, 32'hFFFF_FFFF, CONC_TOP, 1'b0, 1'b0);
		send_sample(2'd1, 1,            0,        1'b0, 1'b1);
		// all-ones fields then all-zero: negative full interval
		send_sample(2'd3, 32'hFFFF_FFFF, CONC_TOP, 1'b1, 1'b0);
		send_sample(2'd3, 0,             0,        1'b0, 1'b1);

		// -- random --
		while (n_items < TOTAL_ITEMS) begin
			// one full drain with the sender parked
			if (!drained && n_items >= DRAIN_ITEMS) begin
				drained = 1'b1;
				samples.valid <= 1'b0;
				do @(posedge clk); while (stats.owed.size() != 0);
			end
			calm = (n_items >= CALM_FROM && n_items < CALM_TO);
			pick = $urandom_range(0, 99);
			comp = $urandom_range(0, 3);
			if (pick < 70) begin
				// well-formed cycle with random content
				len  = $urandom_range(1, 12);
				mode = $urandom_range(0, 3);
				t    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 26);
				for (int k = 0; k < len; k++) begin
					if (k > 0) begin
						case ($urandom_range(0, 15))
							0: ; // repeated time
							1: t = t - $urandom_range(0, 1 << 22);
							2: t = $urandom;
							default: t = t + $urandom_range(1, 1 << 22);
						endcase
					end
					case (mode)
						0: c = $urandom_range(0, 32'h3_FFFF);
						1: c = $urandom_range(0, 3) << 16; // few levels: flats and ties
						2: c = $urandom;
						default: c = CONC_TOP - $urandom_range(0, 3);
					endcase
					send_sample(comp, t, c, k == 0, k == len - 1);
				end
			end else if (pick < 82) begin
				// Pump: each round gains one full-span, full-height segment and
				// loses nothing, so the cycle sum hits the rails from nine rounds on and the
				// cumulative sum builds toward them. Swapping the ends pumps negative.
				lo = 32'd0;
				hi = 32'hFFFF_FFFF;
				if ($urandom_range(0, 1)) begin
					lo = 32'hFFFF_FFFF;
					hi = 32'd0;
				end
				rounds = $urandom_range(4, 12);
				send_sample(comp, lo, CONC_TOP, 1'b1, 1'b0);
				for (int k = 0; k < rounds; k++) begin
					send_sample(comp, hi, CONC_TOP, 1'b0, 1'b0);
					send_sample(comp, hi, 0, 1'b0, 1'b0);
					send_sample(comp, lo, 0, 1'b0, 1'b0);
					if (k == rounds - 1)
						send_sample(comp, $urandom_range(0, 1) ? lo : (lo ^ 32'd1),
							CONC_TOP, 1'b0, 1'b1);
					else
						send_sample(comp, lo, CONC_TOP, 1'b0, 1'b0);
				end
			end else begin
				// noise: random marks and fields
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_sample($urandom_range(0, 3), $urandom, $urandom,
						$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
			end
		end
		calm = 1'b0;

		// wind down: everything owed must arrive, then watch for strays
		samples.valid <= 1'b0;
		do @(posedge clk); while (stats.owed.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stats.owed.size() != 0)
			$display("%0d results never arrived", stats.owed.size());
		if (stats.mismatches == 0 && stats.owed.size() == 0) begin
			$display("tb: success");
		end else begin
			if (stats.mismatches > MAX_REPORTS)
				$display("%0d mismatches in all", stats.mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* curve_cycle_statistics_core.f */
+incdir+hw/rtl
hw/rtl/cstat_pkg.sv
hw/rtl/cstat_stream_if.sv
hw/rtl/curve_cycle_statistics_core.sv
dv/tb_curve_cycle_statistics_core.sv
